// ===== src/kcl_pkg.sv =====
// Shared types, codes and reset constants for the keypad code lock.
package kcl_pkg;

  // Code geometry: six digits, compared as two weighted groups of three
  localparam int CODE_DIGITS = 6;
  localparam int DIGIT_W     = 5;
  localparam int PTR_W       = 3;
  localparam int SUM_W       = 11;

  typedef logic [DIGIT_W-1:0]                  kcl_digit_t;
  typedef logic [CODE_DIGITS-1:0][DIGIT_W-1:0] kcl_code_t;
  typedef logic [PTR_W-1:0]                    kcl_ptr_t;

  localparam kcl_digit_t BLANK_DIGIT = 5'd16;
  localparam kcl_ptr_t   LAST_POS    = 3'd5;
  localparam kcl_ptr_t   NEXT_TO_LAST_POS = 3'd4;

  // Entry 0 is the first digit: 6,5,4,3,2,1
  localparam kcl_code_t DEFAULT_CODE = {5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6};
  localparam kcl_code_t BLANK_CODE   = {CODE_DIGITS{BLANK_DIGIT}};

  // Item kinds
  localparam logic [1:0] FUNC_KEY    = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_SENSOR = 2'd2;

  // Key codes
  localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [3:0] KEY_CHANGE     = 4'd10;
  localparam logic [3:0] KEY_RESET      = 4'd11;
  localparam logic [3:0] KEY_CONFIRM    = 4'd12;
  localparam logic [3:0] KEY_EXIT       = 4'd13;

  // Configuration register indexes
  localparam logic [2:0] CFG_NEAR_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_DOOR_TICKS     = 3'd1;
  localparam logic [2:0] CFG_ALARM_TICKS    = 3'd2;
  localparam logic [2:0] CFG_ERROR_LIMIT    = 3'd3;
  localparam logic [2:0] CFG_AUTO_START     = 3'd4;
  localparam logic [2:0] CFG_AUTO_END       = 3'd5;

  // Configuration reset values
  localparam logic [9:0]  NEAR_THRESHOLD_RST = 10'd30;
  localparam logic [15:0] DOOR_TICKS_RST     = 16'd5000;
  localparam logic [15:0] ALARM_TICKS_RST    = 16'd3000;
  localparam logic [3:0]  ERROR_LIMIT_RST    = 4'd3;
  localparam logic [5:0]  AUTO_START_RST     = 6'h07;
  localparam logic [5:0]  AUTO_END_RST       = 6'h21;

  localparam logic [9:0]  DISTANCE_RST = 10'd999;

  // Entry submode
  typedef enum logic [1:0] {
    MODE_UNLOCK = 2'd0,
    MODE_VERIFY = 2'd1,
    MODE_NEW    = 2'd2
  } kcl_mode_t;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] key_code;
    logic [9:0] distance_cm;
    logic [5:0] hour_bcd;
  } kcl_item_t;

  typedef struct packed {
    logic [9:0]  near_threshold_cm;
    logic [15:0] door_open_ticks;
    logic [15:0] alarm_ticks;
    logic [3:0]  error_limit;
    logic [5:0]  auto_start_hour;
    logic [5:0]  auto_end_hour;
  } kcl_cfg_t;

  typedef struct packed {
    logic       door_open;
    logic       alarm_on;
    logic       manual_active;
    logic [1:0] entry_mode;
    logic [2:0] entry_position;
    logic [3:0] error_count;
  } kcl_result_t;

endpackage

// ===== src/kcl_code_cmp.sv =====
// Code comparator: two weighted three-digit sums of entry against stored code.
module kcl_code_cmp (
  input  kcl_pkg::kcl_code_t entry_code,
  input  kcl_pkg::kcl_code_t stored_code,
  output logic               match
);

  // 100*a + 10*b + c on five-bit digits, blanks included
  function automatic logic [kcl_pkg::SUM_W-1:0] weighted(
    input kcl_pkg::kcl_digit_t a,
    input kcl_pkg::kcl_digit_t b,
    input kcl_pkg::kcl_digit_t c
  );
    logic [kcl_pkg::SUM_W-1:0] wa;
    logic [kcl_pkg::SUM_W-1:0] wb;
    logic [kcl_pkg::SUM_W-1:0] wc;
    wa = {6'd0, a};
    wb = {6'd0, b};
    wc = {6'd0, c};
    return wa * 11'd100 + wb * 11'd10 + wc;
  endfunction

  logic [kcl_pkg::SUM_W-1:0] entry_hi, entry_lo, stored_hi, stored_lo;

  assign entry_hi  = weighted(entry_code[0], entry_code[1], entry_code[2]);
  assign entry_lo  = weighted(entry_code[3], entry_code[4], entry_code[5]);
  assign stored_hi = weighted(stored_code[0], stored_code[1], stored_code[2]);
  assign stored_lo = weighted(stored_code[3], stored_code[4], stored_code[5]);

  assign match = (entry_hi == stored_hi) && (entry_lo == stored_lo);

endmodule

// ===== src/kcl_core.sv =====
// Lock state registers and the next-state logic for one transaction.
module kcl_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  kcl_pkg::kcl_item_t    item,
  input  kcl_pkg::kcl_cfg_t     cfg,
  output kcl_pkg::kcl_result_t  res
);

  kcl_pkg::kcl_code_t stored_r, stored_nxt;
  kcl_pkg::kcl_code_t entry_r, entry_nxt;
  kcl_pkg::kcl_ptr_t  ptr_r, ptr_nxt, put_pos;
  kcl_pkg::kcl_mode_t mode_r, mode_nxt;
  logic [3:0]         wrong_r, wrong_nxt, wrong_inc;
  logic               manual_r, manual_nxt;
  logic [9:0]         dist_r, dist_nxt;
  logic [15:0]        door_r, door_nxt, door_dec, door_load;
  logic [15:0]        alarm_r, alarm_nxt, alarm_dec, alarm_load;

  logic match;
  logic key_ev, k_reset, k_change, k_exit, k_digit, k_confirm;
  logic tick, sensor, in_code_mode, check_mode;
  logic good, wrong, alarm_fire, man_door_req, auto_door_req;

  kcl_code_cmp u_cmp (
    .entry_code  (entry_r),
    .stored_code (stored_r),
    .match       (match)
  );

  // Key decode; keys count only in manual mode
  assign key_ev    = fire && (item.func == kcl_pkg::FUNC_KEY) && manual_r;
  assign tick      = fire && (item.func == kcl_pkg::FUNC_TICK);
  assign sensor    = fire && (item.func == kcl_pkg::FUNC_SENSOR);
  assign in_code_mode = (mode_r == kcl_pkg::MODE_VERIFY) || (mode_r == kcl_pkg::MODE_NEW);
  assign check_mode   = (mode_r != kcl_pkg::MODE_NEW);

  assign k_reset   = key_ev && (item.key_code == kcl_pkg::KEY_RESET);
  assign k_change  = key_ev && (item.key_code == kcl_pkg::KEY_CHANGE);
  assign k_exit    = key_ev && (item.key_code == kcl_pkg::KEY_EXIT) && in_code_mode;
  assign k_digit   = key_ev && (item.key_code <= kcl_pkg::KEY_LAST_DIGIT);
  assign k_confirm = key_ev && (item.key_code == kcl_pkg::KEY_CONFIRM);

  // Code check on confirm in unlock or verify mode
  assign wrong_inc    = wrong_r + 4'd1;
  assign good         = k_confirm && check_mode && match;
  assign wrong        = k_confirm && check_mode && !match;
  assign alarm_fire   = wrong && (wrong_inc >= cfg.error_limit);
  assign man_door_req = good && (mode_r != kcl_pkg::MODE_VERIFY);

  // Submode next state
  always_comb begin
    mode_nxt = mode_r;
    if (k_change) begin
      mode_nxt = kcl_pkg::MODE_VERIFY;
    end else if (k_exit) begin
      mode_nxt = kcl_pkg::MODE_UNLOCK;
    end else if (k_confirm) begin
      unique case (mode_r)
        kcl_pkg::MODE_NEW: mode_nxt = kcl_pkg::MODE_UNLOCK;
        kcl_pkg::MODE_VERIFY: begin
          if (match) begin
            mode_nxt = kcl_pkg::MODE_NEW;
          end else if (alarm_fire) begin
            mode_nxt = kcl_pkg::MODE_UNLOCK;
          end
        end
        default: mode_nxt = mode_r;
      endcase
    end
  end

  // Entry buffer, stored code and error count
  assign put_pos = (ptr_r < kcl_pkg::LAST_POS) ? ptr_r : kcl_pkg::LAST_POS;

  always_comb begin
    entry_nxt  = entry_r;
    ptr_nxt    = ptr_r;
    stored_nxt = stored_r;
    wrong_nxt  = wrong_r;
    if (k_change || k_exit || k_confirm) begin
      entry_nxt = kcl_pkg::BLANK_CODE;
      ptr_nxt   = '0;
    end else if (k_digit) begin
      entry_nxt[put_pos] = {1'b0, item.key_code};
      ptr_nxt = (ptr_r >= kcl_pkg::NEXT_TO_LAST_POS) ? kcl_pkg::LAST_POS : ptr_r + 3'd1;
    end
    if (k_reset) begin
      stored_nxt = kcl_pkg::DEFAULT_CODE;
    end else if (k_confirm && !check_mode) begin
      stored_nxt = entry_r;
    end
    if (good || alarm_fire) begin
      wrong_nxt = '0;
    end else if (wrong) begin
      wrong_nxt = wrong_inc;
    end
  end

  // Sensor update selects the mode; automatic check uses the updated values
  always_comb begin
    dist_nxt   = sensor ? item.distance_cm : dist_r;
    manual_nxt = manual_r;
    if (sensor) begin
      manual_nxt = !((item.hour_bcd >= cfg.auto_start_hour) &&
                     (item.hour_bcd <= cfg.auto_end_hour));
    end
  end

  assign auto_door_req = fire && !manual_nxt && (dist_nxt < cfg.near_threshold_cm);

  // Timers: tick counts down, a request loads only an idle timer
  assign door_dec   = (tick && (door_r != '0)) ? door_r - 16'd1 : door_r;
  assign alarm_dec  = (tick && (alarm_r != '0)) ? alarm_r - 16'd1 : alarm_r;
  assign door_load  = (cfg.door_open_ticks != '0) ? cfg.door_open_ticks : 16'd1;
  assign alarm_load = (cfg.alarm_ticks != '0) ? cfg.alarm_ticks : 16'd1;

  always_comb begin
    door_nxt  = door_dec;
    alarm_nxt = alarm_dec;
    if ((man_door_req || auto_door_req) && (door_dec == '0)) begin
      door_nxt = door_load;
    end
    if (alarm_fire && (alarm_dec == '0)) begin
      alarm_nxt = alarm_load;
    end
  end

  // Result fields come from the state after this transaction
  always_comb begin
    res.door_open      = (door_nxt != '0);
    res.alarm_on       = (alarm_nxt != '0);
    res.manual_active  = manual_nxt;
    res.entry_mode     = mode_nxt;
    res.entry_position = ptr_nxt;
    res.error_count    = wrong_nxt;
  end

  // State registers advance once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r <= kcl_pkg::DEFAULT_CODE;
      entry_r  <= kcl_pkg::BLANK_CODE;
      ptr_r    <= '0;
      mode_r   <= kcl_pkg::MODE_UNLOCK;
      wrong_r  <= '0;
      manual_r <= 1'b1;
      dist_r   <= kcl_pkg::DISTANCE_RST;
      door_r   <= '0;
      alarm_r  <= '0;
    end else if (fire) begin
      stored_r <= stored_nxt;
      entry_r  <= entry_nxt;
      ptr_r    <= ptr_nxt;
      mode_r   <= mode_nxt;
      wrong_r  <= wrong_nxt;
      manual_r <= manual_nxt;
      dist_r   <= dist_nxt;
      door_r   <= door_nxt;
      alarm_r  <= alarm_nxt;
    end
  end

endmodule

// ===== src/keypad_code_lock_controller.sv =====
// Top level of the keypad code lock: channel registers, configuration, core.
//
// Usage: every input transaction is a key event, a millisecond tick or a
// sensor update, chosen by in_tuser. Each one yields exactly one result
// transaction with the door, alarm, mode, entry position and error count
// as they stand after that input.
// Path: an accepted input goes into the input register, and its result into
// the result register, which drives out_tvalid, once the result side is free.
// Throughput: one transaction per clock unless out_tready stalls; the input
// register feeds the lock state logic and the result register in the same
// cycle, and the state updates on that edge, so the next item sees it at once.
// Stall: while out_tready is low the result register holds; one more item
// waits in the input register, after which in_tready drops.
// Reset (rst_n low, synchronous): both channel registers empty, code
// 654321, entry blank, unlock submode, manual mode, distance 999, door
// closed, alarm off, configuration at its defaults. Configuration writes
// take effect on the edge where cfg_we is high; unknown indexes are ignored.
module keypad_code_lock_controller (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // key_code[3:0], distance_cm[13:4], hour_bcd[19:14], zero
  input  logic [1:0]  in_tuser,   // func[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // door_open[0], alarm_on[1], manual_active[2],
                                  // entry_mode[4:3], entry_position[7:5],
                                  // error_count[11:8], zero
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic                 in_valid_r;
  kcl_pkg::kcl_item_t   item_r;
  logic                 out_valid_r;
  kcl_pkg::kcl_result_t res_r;
  kcl_pkg::kcl_result_t res;
  kcl_pkg::kcl_cfg_t    cfg_r;
  logic                 out_free, fire;

  assign out_free  = !out_valid_r || out_tready;
  assign fire      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.func        <= in_tuser;
      item_r.key_code    <= in_tdata[3:0];
      item_r.distance_cm <= in_tdata[13:4];
      item_r.hour_bcd    <= in_tdata[19:14];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_threshold_cm <= kcl_pkg::NEAR_THRESHOLD_RST;
      cfg_r.door_open_ticks   <= kcl_pkg::DOOR_TICKS_RST;
      cfg_r.alarm_ticks       <= kcl_pkg::ALARM_TICKS_RST;
      cfg_r.error_limit       <= kcl_pkg::ERROR_LIMIT_RST;
      cfg_r.auto_start_hour   <= kcl_pkg::AUTO_START_RST;
      cfg_r.auto_end_hour     <= kcl_pkg::AUTO_END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kcl_pkg::CFG_NEAR_THRESHOLD: cfg_r.near_threshold_cm <= cfg_wdata[9:0];
        kcl_pkg::CFG_DOOR_TICKS:     cfg_r.door_open_ticks   <= cfg_wdata;
        kcl_pkg::CFG_ALARM_TICKS:    cfg_r.alarm_ticks       <= cfg_wdata;
        kcl_pkg::CFG_ERROR_LIMIT:    cfg_r.error_limit       <= cfg_wdata[3:0];
        kcl_pkg::CFG_AUTO_START:     cfg_r.auto_start_hour   <= cfg_wdata[5:0];
        kcl_pkg::CFG_AUTO_END:       cfg_r.auto_end_hour     <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // Lock state and per-transaction logic
  kcl_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r.error_count, res_r.entry_position, res_r.entry_mode,
                       res_r.manual_active, res_r.alarm_on, res_r.door_open};

  // Entry pointer never passes the last digit
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:5] <= 3'd5))
    else $error("entry position beyond last digit");

  // Submode code 3 is never produced
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:3] != 2'd3))
    else $error("invalid entry mode");

  // A waiting item is kept while the result side is stalled
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_free) |=> in_valid_r)
    else $error("waiting item dropped during stall");

  // Both registers full and stalled: no new transaction can be taken
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while both stages are full");

endmodule
